// ===== hw/rtl/ara_pkg.sv =====
// ----------------------------------------------------------------------------
// Address range allocator package
// Shared constants, types and codes for the extent allocator.
// ----------------------------------------------------------------------------
package ara_pkg;

  localparam int unsigned MaxExtents = 64;
  localparam int unsigned IdxW       = $clog2(MaxExtents);
  localparam int unsigned CntW       = $clog2(MaxExtents + 1);
  localparam int unsigned AddrW      = 64;
  localparam int unsigned ExtW       = 2 * AddrW;

  localparam logic [1:0] CfgRegionStart = 2'd0;
  localparam logic [1:0] CfgRegionEnd   = 2'd1;
  localparam logic [1:0] CfgPageShift   = 2'd2;

  localparam logic [1:0] StatusDone = 2'd0;
  localparam logic [1:0] StatusFail = 2'd1;
  localparam logic [1:0] StatusFull = 2'd2;

  localparam logic OpAlloc = 1'b0;
  localparam logic OpFree  = 1'b1;

  typedef enum logic [3:0] {
    StIdle,
    StRound,
    StCheck,
    StRead,
    StWait,
    StEval,
    StShiftRd,
    StShiftWait,
    StShiftWr,
    StWrite,
    StDone
  } state_e;

endpackage

// ===== hw/rtl/ara_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ara_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hw/rtl/address_range_allocator_top.sv =====
// ----------------------------------------------------------------------------
// Address range allocator
// First-fit allocator over a sorted table of free extents held in a RAM.
// ----------------------------------------------------------------------------
// Channel   Direction  Signals
// request   in         start_i, busy_o, operation_i, address_i, size_bytes_i
// result    out        done_o, result_address_o, status_o
// config    in         cfg_we_i, cfg_index_i, cfg_wdata_i
//
// A request walks the extent table one entry at a time through the one RAM read
// port (read, wait, evaluate); an insert or remove shifts the tail one entry at a
// time (read, wait, write).
// Reset and region writes rebuild the table at once (count and entry-0 flag only).
// The result strobe lasts one cycle; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module address_range_allocator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        operation_i,
  input  logic [63:0] address_i,
  input  logic [63:0] size_bytes_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_wdata_i,
  output logic        done_o,
  output logic [63:0] result_address_o,
  output logic [1:0]  status_o
);

  localparam int unsigned IdxW = ara_pkg::IdxW;
  localparam int unsigned CntW = ara_pkg::CntW;

  ara_pkg::state_e state_q, state_d;

  logic [63:0] rs_q, re_q;
  logic [4:0]  ps_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic        op_q;
  logic [63:0] base_q, base_d, size_q, size_d, last_q, last_d;
  logic [CntW-1:0] i_q, i_d;
  logic [CntW-1:0] k_q, k_d;
  logic [63:0] pe_q, pe_d;      // end of previous extent
  logic [63:0] pst_q, pst_d;    // start of previous extent
  logic [1:0]  st_q, st_d;
  logic [63:0] res_q, res_d;
  // pending writes after shift: first write start, end and position
  logic [63:0] ws_q, ws_d, we2_q, we2_d;
  logic [CntW-1:0] wpos_q, wpos_d;
  logic        ins_q, ins_d;     // shift direction: 1 insert (up), 0 remove
  logic        w2_q, w2_d;       // second write pending
  logic [63:0] ws2_q, ws2_d, we3_q, we3_d;
  logic [CntW-1:0] wpos2_q, wpos2_d;
  logic        done_q, done_d;

  logic            ram_we;
  logic [IdxW-1:0] ram_wa, ram_ra;
  logic [127:0]    ram_wd, ram_rd;

  ara_ram #(.Width(128), .Depth(ara_pkg::MaxExtents)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_wa),
    .wdata_i(ram_wd),
    .raddr_i(ram_ra),
    .rdata_o(ram_rd)
  );

  wire [63:0] cur_s = ram_rd[127:64];
  wire [63:0] cur_e = ram_rd[63:0];
  // entry 0 after rebuild lives in the region registers until rewritten
  logic        e0_reg_q;
  logic [63:0] s_i, e_i;
  always_comb begin
    s_i = cur_s;
    e_i = cur_e;
    if (e0_reg_q && i_q == '0) begin
      s_i = rs_q;
      e_i = re_q;
    end
  end

  logic [63:0] mask;
  assign mask = (64'd1 << ps_q) - 64'd1;

  wire rebuild = cfg_we_i && (cfg_index_i == ara_pkg::CfgRegionStart ||
                              cfg_index_i == ara_pkg::CfgRegionEnd);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ara_pkg::StIdle;
      rs_q     <= '0;
      re_q     <= '1;
      ps_q     <= 5'd12;
      cnt_q    <= CntW'(1);
      e0_reg_q <= 1'b1;
      done_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          ara_pkg::CfgRegionStart: rs_q <= cfg_wdata_i;
          ara_pkg::CfgRegionEnd:   re_q <= cfg_wdata_i;
          ara_pkg::CfgPageShift:   ps_q <= cfg_wdata_i[4:0];
          default: ;
        endcase
      end
      if (rebuild) begin
        e0_reg_q <= 1'b1;
        if (cfg_index_i == ara_pkg::CfgRegionStart) begin
          cnt_q <= (cfg_wdata_i <= re_q) ? CntW'(1) : '0;
        end else begin
          cnt_q <= (rs_q <= cfg_wdata_i) ? CntW'(1) : '0;
        end
      end else begin
        if (ram_we && ram_wa == '0) begin
          e0_reg_q <= 1'b0;
        end
        cnt_q <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d; size_q <= size_d; last_q <= last_d;
    i_q <= i_d; k_q <= k_d; pe_q <= pe_d; pst_q <= pst_d; st_q <= st_d; res_q <= res_d;
    ws_q <= ws_d; we2_q <= we2_d; wpos_q <= wpos_d; ins_q <= ins_d;
    w2_q <= w2_d; ws2_q <= ws2_d; we3_q <= we3_d; wpos2_q <= wpos2_d;
    if (state_q == ara_pkg::StIdle && start_i) begin
      op_q <= operation_i;
    end
  end

  // next-state and datapath
  always_comb begin
    logic [63:0] rem, add;
    logic        lo_ok, hi_ok, mp, mn, at_end;
    logic [64:0] sum;
    state_d = state_q;
    cnt_d = cnt_q;
    base_d = base_q; size_d = size_q; last_d = last_q;
    i_d = i_q; k_d = k_q; pe_d = pe_q; pst_d = pst_q; st_d = st_q; res_d = res_q;
    ws_d = ws_q; we2_d = we2_q; wpos_d = wpos_q; ins_d = ins_q;
    w2_d = w2_q; ws2_d = ws2_q; we3_d = we3_q; wpos2_d = wpos2_q;
    done_d = 1'b0;
    rem = '0; add = '0; sum = '0;
    lo_ok = 1'b0; hi_ok = 1'b0; mp = 1'b0; mn = 1'b0;
    at_end = (i_q == cnt_q);
    case (state_q)
      ara_pkg::StIdle: begin
        if (start_i) begin
          base_d  = address_i;
          size_d  = size_bytes_i;
          state_d = ara_pkg::StRound;
        end
      end
      ara_pkg::StRound: begin
        base_d = base_q & ~mask;
        rem = size_q & mask;
        if (size_q != '0 && rem != '0) begin
          add = (mask - rem) + 64'd1;
          sum = {1'b0, size_q} + {1'b0, add};
          size_d = sum[64] ? 64'd0 : sum[63:0];
        end
        state_d = ara_pkg::StCheck;
      end
      ara_pkg::StCheck: begin
        sum = {1'b0, base_q} + {1'b0, size_q - 64'd1};
        st_d = ara_pkg::StatusFail;
        res_d = '0;
        i_d = '0;
        w2_d = 1'b0;
        last_d = sum[63:0];
        if (size_q == '0 || sum[64]) begin
          state_d = ara_pkg::StDone;
        end else begin
          state_d = ara_pkg::StRead;
        end
      end
      ara_pkg::StRead: begin
        state_d = ara_pkg::StWait;
      end
      ara_pkg::StWait: begin
        state_d = ara_pkg::StEval;
      end
      ara_pkg::StEval: begin
        state_d = ara_pkg::StRead;
        if (op_q == ara_pkg::OpAlloc) begin
          if (at_end) begin
            state_d = ara_pkg::StDone;
          end else if (e_i - s_i < size_q - 64'd1) begin
            i_d = i_q + CntW'(1);
          end else if (s_i >= base_q) begin
            st_d = ara_pkg::StatusDone;
            res_d = s_i;
            if (e_i - s_i == size_q - 64'd1) begin
              ins_d = 1'b0; k_d = i_q; cnt_d = cnt_q - CntW'(1);
              // park the closing write on the slot freed past the last extent
              wpos_d = cnt_q - CntW'(1);
              state_d = ara_pkg::StShiftRd;
            end else begin
              ws_d = s_i + size_q; we2_d = e_i; wpos_d = i_q;
              state_d = ara_pkg::StWrite;
            end
          end else if (e_i >= last_q) begin
            if (e_i > last_q && cnt_q >= CntW'(ara_pkg::MaxExtents)) begin
              st_d = ara_pkg::StatusFull;
              state_d = ara_pkg::StDone;
            end else begin
              st_d = ara_pkg::StatusDone;
              res_d = base_q;
              ws_d = s_i; we2_d = base_q - 64'd1; wpos_d = i_q;
              if (e_i > last_q) begin
                w2_d = 1'b1; ws2_d = last_q + 64'd1; we3_d = e_i;
                wpos2_d = i_q + CntW'(1);
                ins_d = 1'b1; k_d = cnt_q; cnt_d = cnt_q + CntW'(1);
                state_d = ara_pkg::StShiftRd;
              end else begin
                state_d = ara_pkg::StWrite;
              end
            end
          end else begin
            i_d = i_q + CntW'(1);
          end
        end else begin
          lo_ok = (i_q == '0) ? (base_q >= rs_q) : (base_q > pe_q);
          hi_ok = at_end ? (last_q <= re_q) : (last_q < s_i);
          mp = (i_q != '0) && (base_q - 64'd1 == pe_q);
          mn = !at_end && (last_q + 64'd1 == s_i);
          if (!lo_ok || !hi_ok) begin
            if (at_end) begin
              state_d = ara_pkg::StDone;
            end else begin
              pe_d = e_i;
              pst_d = s_i;
              i_d = i_q + CntW'(1);
            end
          end else begin
            st_d = ara_pkg::StatusDone;
            res_d = base_q;
            if (mp && mn) begin
              // widen previous extent, drop this one
              ws_d = pst_q; wpos_d = i_q - CntW'(1); we2_d = e_i;
              w2_d = 1'b0;
              ins_d = 1'b0; k_d = i_q; cnt_d = cnt_q - CntW'(1);
              state_d = ara_pkg::StShiftRd;
            end else if (mp) begin
              wpos_d = i_q - CntW'(1); ws_d = pst_q; we2_d = last_q;
              state_d = ara_pkg::StWrite;
            end else if (mn) begin
              wpos_d = i_q; ws_d = base_q; we2_d = e_i;
              state_d = ara_pkg::StWrite;
            end else if (cnt_q >= CntW'(ara_pkg::MaxExtents)) begin
              st_d = ara_pkg::StatusFull;
              res_d = '0;
              state_d = ara_pkg::StDone;
            end else begin
              wpos2_d = i_q;
              wpos_d = i_q; ws_d = base_q; we2_d = last_q;
              ins_d = 1'b1; k_d = cnt_q; cnt_d = cnt_q + CntW'(1);
              state_d = ara_pkg::StShiftRd;
            end
          end
        end
      end
      ara_pkg::StShiftRd: begin
        // insert: move k-1 to k while k > pos; remove: move k+1 to k
        if (ins_q ? (k_q <= wpos2_q) : (k_q >= cnt_q)) begin
          state_d = ara_pkg::StWrite;
        end else begin
          state_d = ara_pkg::StShiftWait;
        end
      end
      ara_pkg::StShiftWait: begin
        state_d = ara_pkg::StShiftWr;
      end
      ara_pkg::StShiftWr: begin
        k_d = ins_q ? k_q - CntW'(1) : k_q + CntW'(1);
        state_d = ara_pkg::StShiftRd;
      end
      ara_pkg::StWrite: begin
        if (w2_q) begin
          w2_d = 1'b0;
        end else begin
          state_d = ara_pkg::StDone;
        end
      end
      ara_pkg::StDone: begin
        done_d = 1'b1;
        state_d = ara_pkg::StIdle;
      end
      default: state_d = ara_pkg::StIdle;
    endcase
  end

  // RAM port control; shifts copy one entry, the final writes take the stage words
  logic [IdxW-1:0] k_src;
  always_comb begin
    k_src  = ins_q ? IdxW'(k_q - CntW'(1)) : IdxW'(k_q + CntW'(1));
    ram_ra = IdxW'(i_q);
    ram_we = 1'b0;
    ram_wa = IdxW'(wpos_q);
    ram_wd = '0;
    case (state_q)
      ara_pkg::StShiftRd, ara_pkg::StShiftWait: ram_ra = k_src;
      ara_pkg::StShiftWr: begin
        ram_ra = k_src;
        ram_we = 1'b1;
        ram_wa = IdxW'(k_q);
        ram_wd = (e0_reg_q && k_src == '0) ? {rs_q, re_q} : ram_rd;
      end
      ara_pkg::StWrite: begin
        ram_we = 1'b1;
        ram_ra = IdxW'(wpos_q);
        if (w2_q) begin
          ram_wa = IdxW'(wpos2_q);
          ram_wd = {ws2_q, we3_q};
        end else begin
          ram_wd = {ws_q, we2_q};
        end
      end
      default: ;
    endcase
  end

  assign busy_o           = (state_q != ara_pkg::StIdle);
  assign done_o           = done_q;
  assign result_address_o = (st_q == ara_pkg::StatusDone) ? res_q : '0;
  assign status_o         = st_q;

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Address range allocator testbench
// Sends allocate and free requests through several region and page settings.
// Each result is compared with an extent-table predictor kept in the bench.
// ----------------------------------------------------------------------------
module tb_top;
  import ara_pkg::*;

  localparam int unsigned WdogLimit = 20000;
  localparam logic [1:0]  CfgSpare  = 2'd3;
  localparam logic [63:0] AllOnes   = '1;

  typedef struct {
    logic [63:0] addr;
    logic [1:0]  status;
  } alloc_res_t;

  typedef struct {
    logic        op;
    logic [63:0] addr;
    logic [63:0] size;
    bit          typed;
    logic [63:0] res_addr;
    logic [1:0]  res_status;
  } stim_row_t;

  typedef struct {
    logic [63:0] base;
    logic [63:0] size;
  } span_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic        operation_i = OpAlloc;
  logic [63:0] address_i = '0;
  logic [63:0] size_bytes_i = '0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = CfgRegionStart;
  logic [63:0] cfg_wdata_i = '0;
  logic        done_o;
  logic [63:0] result_address_o;
  logic [1:0]  status_o;

  // free extent table mirror
  logic [63:0] ext_lo [MaxExtents];
  logic [63:0] ext_hi [MaxExtents];
  int          ext_cnt;
  logic [63:0] reg_rstart = '0;
  logic [63:0] reg_rend = AllOnes;
  logic [4:0]  reg_shift = 5'd12;

  alloc_res_t  pending_q[$];
  span_t       held_q[$];
  int          errors = 0;
  int          idle_cycles = 0;
  int          burst_left = 0;

  always #4 clk_i = ~clk_i;

  address_range_allocator_top dut (.*);

  // ---------------------------------------------------------------- predictor
  task automatic open_slot(input int pos, input logic [63:0] s, input logic [63:0] e);
    for (int k = ext_cnt; k > pos; k--) begin
      ext_lo[k] = ext_lo[k-1];
      ext_hi[k] = ext_hi[k-1];
    end
    ext_lo[pos] = s;
    ext_hi[pos] = e;
    ext_cnt++;
  endtask

  task automatic close_slot(input int pos);
    for (int k = pos; k + 1 < ext_cnt; k++) begin
      ext_lo[k] = ext_lo[k+1];
      ext_hi[k] = ext_hi[k+1];
    end
    ext_cnt--;
  endtask

  task automatic rebuild_extents();
    if (reg_rstart <= reg_rend) begin
      ext_lo[0] = reg_rstart;
      ext_hi[0] = reg_rend;
      ext_cnt = 1;
    end else begin
      ext_cnt = 0;
    end
  endtask

  task automatic carve(input logic [63:0] base, input logic [63:0] size,
                       input logic [63:0] last, output logic [1:0] st,
                       output logic [63:0] res);
    logic [63:0] s, e;
    st = StatusFail;
    res = '0;
    for (int i = 0; i < ext_cnt; i++) begin
      s = ext_lo[i];
      e = ext_hi[i];
      if (e - s < size - 64'd1) continue;
      if (s >= base) begin
        res = s;
        if (e - s == size - 64'd1) close_slot(i);
        else ext_lo[i] = s + size;
        st = StatusDone;
        return;
      end
      if (e >= last) begin
        if (e > last) begin
          if (ext_cnt >= MaxExtents) begin
            st = StatusFull;
            return;
          end
          open_slot(i + 1, last + 64'd1, e);
        end
        ext_hi[i] = base - 64'd1;
        res = base;
        st = StatusDone;
        return;
      end
    end
  endtask

  task automatic release_span(input logic [63:0] base, input logic [63:0] last,
                              output logic [1:0] st, output logic [63:0] res);
    bit lo_ok, hi_ok, mp, mn;
    st = StatusFail;
    res = '0;
    for (int i = 0; i <= ext_cnt; i++) begin
      lo_ok = (i == 0) ? (base >= reg_rstart) : (base > ext_hi[(i > 0) ? i - 1 : 0]);
      hi_ok = (i == ext_cnt) ? (last <= reg_rend) : (last < ext_lo[i]);
      if (!lo_ok || !hi_ok) continue;
      mp = (i > 0) && (base - 64'd1 == ext_hi[(i > 0) ? i - 1 : 0]);
      mn = (i < ext_cnt) && (last + 64'd1 == ext_lo[i]);
      if (mp && mn) begin
        ext_hi[i-1] = ext_hi[i];
        close_slot(i);
      end else if (mp) begin
        ext_hi[i-1] = last;
      end else if (mn) begin
        ext_lo[i] = base;
      end else begin
        if (ext_cnt >= MaxExtents) begin
          st = StatusFull;
          return;
        end
        open_slot(i, base, last);
      end
      res = base;
      st = StatusDone;
      return;
    end
  endtask

  // round the request to pages and apply it to the table mirror
  task automatic predict_request(input logic op, input logic [63:0] addr,
                                 input logic [63:0] size_in, output alloc_res_t r,
                                 output logic [63:0] rounded);
    logic [63:0] page, mask, base, size, add;
    page = 64'd1 << reg_shift;
    mask = page - 64'd1;
    base = addr & ~mask;
    size = size_in;
    r.addr = '0;
    r.status = StatusFail;
    if (size != 0 && (size & mask) != 0) begin
      add = page - (size & mask);
      if (size > AllOnes - add) size = '0;
      else size = size + add;
    end
    rounded = size;
    if (size != 0 && size - 64'd1 <= AllOnes - base) begin
      if (op == OpAlloc) carve(base, size, base + (size - 64'd1), r.status, r.addr);
      else release_span(base, base + (size - 64'd1), r.status, r.addr);
    end
    if (r.status != StatusDone) r.addr = '0;
  endtask

  // ---------------------------------------------------------------- driving
  task automatic write_region(input logic [63:0] rs, input logic [63:0] re,
                              input logic [4:0] sh);
    cfg_we_i <= 1'b1;
    cfg_index_i <= CfgSpare;
    cfg_wdata_i <= {$urandom, $urandom};
    @(posedge clk_i);
    cfg_index_i <= CfgPageShift;
    cfg_wdata_i <= {59'd0, sh};
    @(posedge clk_i);
    cfg_index_i <= CfgRegionStart;
    cfg_wdata_i <= rs;
    @(posedge clk_i);
    cfg_index_i <= CfgRegionEnd;
    cfg_wdata_i <= re;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    reg_shift = sh;
    reg_rstart = rs;
    reg_rend = re;
    rebuild_extents();
    held_q.delete();
  endtask

  // hold off until every result is back
  task automatic drain();
    start_i <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (pending_q.size() != 0 || busy_o);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic send(input logic op, input logic [63:0] addr, input logic [63:0] size,
                      input bit typed, input logic [63:0] t_addr, input logic [1:0] t_st);
    int gap;
    alloc_res_t r;
    logic [63:0] rounded;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        start_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    start_i <= 1'b1;
    operation_i <= op;
    address_i <= addr;
    size_bytes_i <= size;
    do @(posedge clk_i); while (busy_o);
    predict_request(op, addr, size, r, rounded);
    if (op == OpAlloc && r.status == StatusDone) held_q.push_back('{r.addr, rounded});
    if (typed) begin
      r.addr = t_addr;
      r.status = t_st;
    end
    pending_q.push_back(r);
  endtask

  task automatic random_request(input int window);
    logic [63:0] page, hint, size;
    int          pick;
    span_t       sp;
    page = 64'd1 << reg_shift;
    pick = $urandom_range(0, 99);
    if (pick < 35 && held_q.size() != 0) begin
      pick = $urandom_range(0, held_q.size() - 1);
      sp = held_q[pick];
      held_q.delete(pick);
      // free the span, sometimes a piece of it or unaligned
      if ($urandom_range(0, 3) == 0) sp.size = page;
      send(OpFree, sp.base | ($urandom & (page - 64'd1)), sp.size, 1'b0, '0, StatusDone);
    end else if (pick < 85) begin
      hint = ($urandom_range(0, 1) == 0) ? reg_rstart
           : reg_rstart + ({32'd0, $urandom_range(0, window)} << reg_shift);
      size = ({32'd0, $urandom_range(1, 6)} << reg_shift) - ($urandom & (page - 64'd1));
      send(OpAlloc, hint | ($urandom & (page - 64'd1)), size, 1'b0, '0, StatusDone);
    end else begin
      send(1'($urandom_range(0, 1)), {$urandom, $urandom},
           ($urandom_range(0, 1) == 0) ? {$urandom, $urandom} : {32'd0, $urandom},
           1'b0, '0, StatusDone);
    end
  endtask

  // ---------------------------------------------------------------- checking
  always @(posedge clk_i) begin
    alloc_res_t want;
    if (done_o) begin
      if (pending_q.size() == 0) begin
        $display("%0t: result with nothing pending: addr %h status %0d", $time,
                 result_address_o, status_o);
        errors++;
      end else begin
        want = pending_q.pop_front();
        if (result_address_o !== want.addr) begin
          $display("%0t: result_address expected %h actual %h", $time, want.addr,
                   result_address_o);
          errors++;
        end
        if (status_o !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, status_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WdogLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus
  stim_row_t directed [] = '{
    '{OpAlloc, 64'h0, 64'h0, 1'b1, 64'h0, StatusFail},
    '{OpAlloc, 64'h0, 64'h1, 1'b1, 64'h0, StatusDone},
    '{OpAlloc, 64'h0, AllOnes, 1'b1, 64'h0, StatusFail},
    '{OpFree, 64'h0, AllOnes, 1'b1, 64'h0, StatusFail},
    '{OpAlloc, AllOnes, 64'h1000, 1'b1, 64'hFFFF_FFFF_FFFF_F000, StatusDone},
    '{OpFree, 64'h0, 64'h1, 1'b0, '0, StatusDone},
    '{OpFree, 64'h0, 64'h1, 1'b1, 64'h0, StatusFail},
    '{OpFree, AllOnes, 64'h1000, 1'b0, '0, StatusDone},
    '{OpAlloc, 64'h1_0fff, 64'h1fff, 1'b0, '0, StatusDone},
    '{OpFree, 64'h1_0000, 64'h2000, 1'b0, '0, StatusDone},
    '{OpAlloc, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 1'b0, '0, StatusDone},
    '{OpAlloc, 64'h2000, 64'hFFFF_FFFF_FFFF_E001, 1'b1, 64'h0, StatusFail},
    '{OpFree, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_F001, 1'b0, '0, StatusDone},
    '{OpFree, 64'h5000, 64'h1000, 1'b1, 64'h0, StatusFail},
    '{OpAlloc, 64'h0, 64'hFFFF_FFFF_FFFF_F000, 1'b0, '0, StatusDone}
  };

  initial begin
    rebuild_extents();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[n])
      send(directed[n].op, directed[n].addr, directed[n].size, directed[n].typed,
           directed[n].res_addr, directed[n].res_status);
    drain();

    // fill a small region page by page, then punch holes until the table is full
    write_region(64'h0, 64'd1023, 5'd3);
    for (int n = 0; n < 128; n++) send(OpAlloc, 64'h0, 64'd8, 1'b0, '0, StatusDone);
    for (int n = 0; n < 128; n += 2) send(OpFree, 64'(n * 8), 64'd8, 1'b0, '0, StatusDone);
    send(OpFree, 64'h0, 64'd1, 1'b1, 64'h0, StatusFail);
    send(OpAlloc, 64'd3, 64'd3, 1'b0, '0, StatusDone);
    for (int n = 0; n < 150; n++) random_request(120);
    drain();

    write_region(64'h1000, 64'h1000 + 64 * 4096 - 1, 5'd12);
    for (int n = 0; n < 220; n++) random_request(64);
    drain();

    write_region(64'h0, 64'hFFF, 5'd0);
    for (int n = 0; n < 200; n++) random_request(4000);
    drain();

    write_region(64'h0, AllOnes, 5'd31);
    for (int n = 0; n < 120; n++) random_request(30);
    drain();

    write_region(64'h4000_0000, 64'h4000_0000 + (64'd40 << 30) - 1, 5'd30);
    for (int n = 0; n < 120; n++) random_request(45);
    drain();

    // region start above region end leaves an empty table
    write_region(64'h5000, 64'h4fff, 5'd12);
    send(OpFree, 64'h5000, 64'h1000, 1'b1, 64'h0, StatusFail);
    for (int n = 0; n < 60; n++) random_request(16);
    drain();

    write_region(64'h7000_0000_0000_0000, AllOnes, 5'd20);
    for (int n = 0; n < 250; n++) random_request(200);
    drain();

    repeat (50) @(posedge clk_i);
    if (errors == 0 && pending_q.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/ara_pkg.sv
hw/rtl/ara_ram.sv
hw/rtl/address_range_allocator_top.sv
sim/tb_top.sv
